// ----- rtl/core/fpis_pkg.sv -----
// ----------------------------------------------------------------------------
// fpis_pkg
// Shared types and constants for the fixed-point index search core.
// ----------------------------------------------------------------------------
package fpis_pkg;

   localparam int LEN_W     = 11;   // array_length register width
   localparam int ELEM_IN_W = 16;   // element_value field width
   localparam int INDEX_W   = 10;   // found_index field width
   localparam int RSP_DATA_W = 16;  // found_index padded to whole bytes

   localparam logic ACT_LOAD   = 1'b0;
   localparam logic ACT_SEARCH = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,      // take loads and searches
      ST_RANGE,     // check current range, issue probe read
      ST_PROBE,     // compare probe, split range, push pending half
      ST_POP,       // fetch pending range, or finish when stack empty
      ST_UNSTACK,   // load popped range
      ST_REPORT     // hand result to output register
   } state_type;

   typedef struct packed {
      logic hit;    // element equals its index
      logic left;   // probe index below element: descend left first
      logic push;   // pending range is non-empty
   } probe_flags_type;

endpackage

// ----- rtl/core/fpis_elem_mem.sv -----
// ----------------------------------------------------------------------------
// fpis_elem_mem
// Element store: one write port for loads, one registered read port for probes.
// ----------------------------------------------------------------------------
module fpis_elem_mem #(
   parameter int DEPTH  = 1024,
   parameter int DATA_W = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/fpis_stack_mem.sv -----
// ----------------------------------------------------------------------------
// fpis_stack_mem
// Pending-range stack storage, one write port and one registered read port.
// ----------------------------------------------------------------------------
module fpis_stack_mem #(
   parameter int DEPTH  = 16,
   parameter int DATA_W = 22
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/fpis_probe_unit.sv -----
// ----------------------------------------------------------------------------
// fpis_probe_unit
// Compare / clamp unit: compares a probed element with its index and
// splits the range into the one taken next and the one to push.
// ----------------------------------------------------------------------------
module fpis_probe_unit
   import fpis_pkg::*;
#(
   parameter int AW     = 10,
   parameter int BW     = 11,
   parameter int VALUE_W = 16
) (
   input  logic [AW-1:0]             probe_idx,
   input  logic signed [VALUE_W-1:0] probe_val,
   input  logic [BW-1:0]             len,
   input  logic [BW-1:0]             cur_lo,
   input  logic [BW-1:0]             cur_hi,
   output logic [BW-1:0]             next_lo,
   output logic [BW-1:0]             next_hi,
   output logic [BW-1:0]             push_lo,
   output logic [BW-1:0]             push_hi,
   output probe_flags_type           flags
);

   localparam int CW = ((VALUE_W > BW) ? VALUE_W : BW) + 2;
   localparam logic signed [CW-1:0] ONE_S = CW'(1);

   logic signed [CW-1:0] val_ext;
   logic signed [CW-1:0] idx_ext;
   logic signed [CW-1:0] val_inc;

   function automatic logic [BW-1:0] clamp_bound(input logic signed [CW-1:0] x,
                                                 input logic [BW-1:0] lim);
      logic signed [CW-1:0] lim_s;
      lim_s = signed'(CW'(lim));
      if (x < 0) begin
         clamp_bound = '0;
      end else if (x > lim_s) begin
         clamp_bound = lim;
      end else begin
         clamp_bound = BW'(x);
      end
   endfunction

   always_comb begin
      val_ext = CW'(probe_val);
      idx_ext = signed'(CW'(probe_idx));
      val_inc = val_ext + ONE_S;
      flags.hit  = (val_ext == idx_ext);
      flags.left = (idx_ext < val_ext);
      if (flags.left) begin
         push_lo = clamp_bound(val_ext, len);
         push_hi = cur_hi;
         next_lo = cur_lo;
         next_hi = BW'(probe_idx);
      end else begin
         push_lo = cur_lo;
         push_hi = clamp_bound(val_inc, len);
         next_lo = BW'(probe_idx) + BW'(1);
         next_hi = cur_hi;
      end
      flags.push = (push_hi > push_lo);
   end

endmodule

// ----- rtl/core/fixed_point_index_search_core.sv -----
// ----------------------------------------------------------------------------
// fixed_point_index_search_core
// Loads a sorted signed array one word at a time and searches it for an
// index equal to its element, walking ranges with an explicit stack.
// ----------------------------------------------------------------------------
//  channel | dir | handshake               | payload
//  req     | in  | req_tvalid/req_tready   | tuser: action, tdata: element_value
//  rsp     | out | rsp_tvalid/rsp_tready   | tuser: found, tdata: found_index
//  csr     | in  | csr_valid/csr_ready     | csr_data: array_length
//
//  A load word gives no response word. A search checks each range and, if it
//  is non-empty, reads its probe element; a stack pop fetches and then loads
//  the popped range; an empty stack ends a miss, and every search reports.
//  The registered element read sets the pace; report waits on a held response.
//  req_tready is high only in idle; a waiting response never blocks loads.
//  Synchronous active-high reset clears control, length and load pointer.
// ----------------------------------------------------------------------------
module fixed_point_index_search_core
   import fpis_pkg::*;
#(
   parameter int MAX_ELEMS   = 1024,
   parameter int VALUE_BITS  = 16,
   parameter int STACK_DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // request words
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [ELEM_IN_W-1:0]  req_tdata,   // [15:0] element_value
   input  logic                  req_tuser,   // [0] action
   // response words
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [9:0] found_index, [15:10] zero
   output logic                  rsp_tuser,   // [0] found
   // length register
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [LEN_W-1:0]      csr_data
);

   localparam int AW  = $clog2(MAX_ELEMS);        // element address
   localparam int BW  = $clog2(MAX_ELEMS + 1);    // range bound, holds n
   localparam int SAW = $clog2(STACK_DEPTH);      // stack address
   localparam int SPW = $clog2(STACK_DEPTH + 1);  // stack height

   state_type state_ff, state_in;

   logic [LEN_W-1:0] len_cfg_ff;
   logic [BW-1:0]    load_ptr_ff, load_ptr_in;
   logic [BW-1:0]    len_ff, len_in;            // clamped length for this search
   logic [BW-1:0]    lo_ff, lo_in;
   logic [BW-1:0]    hi_ff, hi_in;
   logic [AW-1:0]    probe_ff, probe_in;
   logic [SPW-1:0]   sp_ff, sp_in;
   logic             hit_ff, hit_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_found_ff, rsp_found_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;

   logic             req_fire;
   logic             out_free;
   logic             range_empty;
   logic [BW:0]      mid_sum;
   logic [AW-1:0]    mid_idx;
   logic             stack_room;

   logic signed [ELEM_IN_W-1:0] req_value_s;
   logic                  elem_wr_en;
   logic [VALUE_BITS-1:0] elem_rd_data;
   logic                  stk_wr_en;
   logic [2*BW-1:0]       stk_rd_data;
   logic [SAW-1:0]        stk_rd_addr;
   logic [SPW-1:0]        sp_dec;

   logic [BW-1:0]   pu_next_lo, pu_next_hi, pu_push_lo, pu_push_hi;
   probe_flags_type pu_flags;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // probe = (lo + hi - 1) / 2; only used when the range is non-empty
   assign range_empty = (hi_ff <= lo_ff);
   assign mid_sum     = {1'b0, lo_ff} + {1'b0, hi_ff} - (BW + 1)'(1);
   assign mid_idx     = AW'(mid_sum[BW:1]);

   assign stack_room  = (sp_ff < SPW'(STACK_DEPTH));
   assign sp_dec      = sp_ff - SPW'(1);
   assign stk_rd_addr = sp_dec[SAW-1:0];

   assign req_value_s = signed'(req_tdata);

   // store full: extra loads are dropped
   assign elem_wr_en = req_fire && (req_tuser == ACT_LOAD) &&
                       (load_ptr_ff < BW'(MAX_ELEMS));

   fpis_elem_mem #(
      .DEPTH  (MAX_ELEMS),
      .DATA_W (VALUE_BITS)
   ) u_elem_mem (
      .clock   (clock),
      .wr_en   (elem_wr_en),
      .wr_addr (load_ptr_ff[AW-1:0]),
      .wr_data (VALUE_BITS'(req_value_s)),
      .rd_addr (mid_idx),
      .rd_data (elem_rd_data)
   );

   fpis_probe_unit #(
      .AW      (AW),
      .BW      (BW),
      .VALUE_W (VALUE_BITS)
   ) u_probe_unit (
      .probe_idx (probe_ff),
      .probe_val (signed'(elem_rd_data)),
      .len       (len_ff),
      .cur_lo    (lo_ff),
      .cur_hi    (hi_ff),
      .next_lo   (pu_next_lo),
      .next_hi   (pu_next_hi),
      .push_lo   (pu_push_lo),
      .push_hi   (pu_push_hi),
      .flags     (pu_flags)
   );

   // pending range pushed only if non-empty and the stack has room;
   // a range that finds the stack full is dropped
   assign stk_wr_en = (state_ff == ST_PROBE) && !pu_flags.hit &&
                      pu_flags.push && stack_room;

   fpis_stack_mem #(
      .DEPTH  (STACK_DEPTH),
      .DATA_W (2 * BW)
   ) u_stack_mem (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (sp_ff[SAW-1:0]),
      .wr_data ({pu_push_lo, pu_push_hi}),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_tuser == ACT_SEARCH)) begin
               state_in = ST_RANGE;
            end
         end
         ST_RANGE: begin
            state_in = range_empty ? ST_POP : ST_PROBE;
         end
         ST_PROBE: begin
            state_in = pu_flags.hit ? ST_REPORT : ST_RANGE;
         end
         ST_POP: begin
            state_in = (sp_ff == '0) ? ST_REPORT : ST_UNSTACK;
         end
         ST_UNSTACK: begin
            state_in = ST_RANGE;
         end
         ST_REPORT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      load_ptr_in  = load_ptr_ff;
      len_in       = len_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      probe_in     = probe_ff;
      sp_in        = sp_ff;
      hit_in       = hit_ff;
      rsp_found_in = rsp_found_ff;
      rsp_index_in = rsp_index_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (elem_wr_en) begin
               load_ptr_in = load_ptr_ff + BW'(1);
            end
            if (req_fire && (req_tuser == ACT_SEARCH)) begin
               // length beyond the store covers the whole store
               if (32'(len_cfg_ff) >= MAX_ELEMS) begin
                  len_in = BW'(MAX_ELEMS);
                  hi_in  = BW'(MAX_ELEMS);
               end else begin
                  len_in = BW'(len_cfg_ff);
                  hi_in  = BW'(len_cfg_ff);
               end
               lo_in  = '0;
               sp_in  = '0;
               hit_in = 1'b0;
            end
         end
         ST_RANGE: begin
            probe_in = mid_idx;
         end
         ST_PROBE: begin
            if (pu_flags.hit) begin
               hit_in = 1'b1;
            end else begin
               lo_in = pu_next_lo;
               hi_in = pu_next_hi;
               if (pu_flags.push && stack_room) begin
                  sp_in = sp_ff + SPW'(1);
               end
            end
         end
         ST_POP: begin
            if (sp_ff != '0) begin
               sp_in = sp_dec;
            end
         end
         ST_UNSTACK: begin
            lo_in = stk_rd_data[2*BW-1:BW];
            hi_in = stk_rd_data[BW-1:0];
         end
         ST_REPORT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = hit_ff;
               rsp_index_in = hit_ff ? INDEX_W'(probe_ff) : '0;
               sp_in        = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_cfg_ff   <= '0;
         load_ptr_ff  <= '0;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_ptr_ff  <= load_ptr_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            len_cfg_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      len_ff       <= len_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      probe_ff     <= probe_in;
      hit_ff       <= hit_in;
      rsp_found_ff <= rsp_found_in;
      rsp_index_ff <= rsp_index_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_index_ff);

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for fixed_point_index_search_core. Stimulus fills the
// element store and mixes loads with searches over many array lengths. A
// scoreboard replays every accepted word on its own model of the store and the
// range-stack search, and checks each response word in order.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import fpis_pkg::*;

   localparam int MAX_ELEMS     = 1024;
   localparam int STACK_DEPTH   = 16;
   localparam int LEN_MAX       = (1 << LEN_W) - 1;
   localparam int ITEM_COUNT    = 1400;  // counted words (ignored loads excluded)
   localparam int QUIET_ITEMS   = 150;   // closing stretch with no idling
   localparam int SETTLE_CYCLES = 8;     // a load may still be in flight
   localparam int LONG_HOLD     = 400;   // response back-pressure stretch

   // -------------------------------------------------------------------------
   // Scoreboard: mirror of the element store, the length register and the
   // divide-and-conquer search; keeps search outcomes in issue order.
   // -------------------------------------------------------------------------
   class index_search_board;
      typedef struct packed {
         logic               found;
         logic [INDEX_W-1:0] position;
      } search_hit_type;

      logic signed [ELEM_IN_W-1:0] elems [MAX_ELEMS];
      int                          fill;
      int                          length;
      int                          errors;
      search_hit_type              expected [$];

      function new();
         fill   = 0;
         length = 0;
         errors = 0;
         foreach (elems[i]) elems[i] = '0;
      endfunction

      function void set_length(logic [LEN_W-1:0] len);
         length = int'(len);
      endfunction

      function int clamp_bound(int x, int n);
         if (x < 0) return 0;
         if (x > n) return n;
         return x;
      endfunction

      // Pending second halves go on a bounded stack; the first half is
      // walked at once. A push onto a full stack is dropped.
      function search_hit_type run_search();
         int             n, lo, hi, probe, value, side_lo, side_hi, depth;
         int             pend_lo [STACK_DEPTH];
         int             pend_hi [STACK_DEPTH];
         bit             have;
         search_hit_type hit;
         n     = (length > MAX_ELEMS) ? MAX_ELEMS : length;
         hit   = '0;
         depth = 0;
         lo    = 0;
         hi    = n;
         have  = 1'b1;
         forever begin
            if (!have) begin
               if (depth == 0) break;
               depth--;
               lo = pend_lo[depth];
               hi = pend_hi[depth];
            end
            have = 1'b0;
            if (hi <= lo) continue;
            probe = (lo + hi - 1) / 2;
            value = int'(elems[probe]);
            if (value == probe) begin
               hit.found    = 1'b1;
               hit.position = probe[INDEX_W-1:0];
               break;
            end
            if (probe < value) begin
               side_lo = clamp_bound(value, n);
               side_hi = hi;
               hi      = probe;
            end else begin
               side_lo = lo;
               side_hi = clamp_bound(value + 1, n);
               lo      = probe + 1;
            end
            if (side_hi > side_lo && depth < STACK_DEPTH) begin
               pend_lo[depth] = side_lo;
               pend_hi[depth] = side_hi;
               depth++;
            end
            have = 1'b1;
         end
         return hit;
      endfunction

      function void note_word(logic act, logic [ELEM_IN_W-1:0] data);
         if (act == ACT_LOAD) begin
            // store full: further loads fall on the floor
            if (fill < MAX_ELEMS) begin
               elems[fill] = data;
               fill++;
            end
         end else begin
            expected.push_back(run_search());
         end
      endfunction

      function void check_result(logic found, logic [RSP_DATA_W-1:0] data);
         search_hit_type          want;
         logic [RSP_DATA_W-1:0]   want_data;
         if (expected.size() == 0) begin
            $display("%0t: response word with no search pending: found=%0b data=0x%0h",
                     $time, found, data);
            errors++;
            return;
         end
         want      = expected.pop_front();
         want_data = {{(RSP_DATA_W-INDEX_W){1'b0}}, want.position};
         if (found !== want.found) begin
            $display("%0t: found mismatch: expected %0b, actual %0b",
                     $time, want.found, found);
            errors++;
         end
         if (data !== want_data) begin
            $display("%0t: found_index mismatch: expected 0x%0h, actual 0x%0h",
                     $time, want_data, data);
            errors++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, DUT and shared bench state
   // -------------------------------------------------------------------------
   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [ELEM_IN_W-1:0]  req_tdata;   // [15:0] element_value
   logic                  req_tuser;   // [0] action
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [9:0] found_index, [15:10] zero
   logic                  rsp_tuser;   // [0] found
   logic                  csr_valid;
   logic                  csr_ready;
   logic [LEN_W-1:0]      csr_data;    // [10:0] array_length

   index_search_board board;
   bit                quiet     = 1'b0;  // no idling on either side
   bit                long_hold = 1'b0;  // request for a long rsp stall
   int                items     = 0;
   int                loads_sent = 0;
   int                elem_level = 10;   // running value for sorted loads

   always #5 clock = ~clock;

   fixed_point_index_search_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // -------------------------------------------------------------------------
   // Monitors: sample handshakes at the edge, before the edge's updates land
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            board.set_length(csr_data);
         if (req_tvalid && req_tready)
            board.note_word(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready)
            board.check_result(rsp_tuser, rsp_tdata);
      end
   end

   // -------------------------------------------------------------------------
   // Response sink: random ready bursts, one long stall on request, none at
   // the end. One assignment per pass, each pass spans at least one edge.
   // -------------------------------------------------------------------------
   initial begin
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold = 1'b0;
         end else if (quiet || $urandom_range(0, 2) != 0) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Driver tasks
   // -------------------------------------------------------------------------

   // One request word; valid stays up afterwards unless a gap or a settle
   // pulls it down, so back-to-back words never toggle it within a step.
   task automatic put(input logic act, input logic [ELEM_IN_W-1:0] val);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= val;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (act == ACT_SEARCH) begin
         items++;
      end else if (loads_sent < MAX_ELEMS) begin
         loads_sent++;
         items++;
      end
   endtask

   // Wait for every pending search to report, then cover a trailing load.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(input int len);
      csr_valid <= 1'b1;
      csr_data  <= len[LEN_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly a non-decreasing walk near the diagonal so matches show up,
   // with occasional jumps, returns to the diagonal and unsorted noise.
   function automatic logic [ELEM_IN_W-1:0] next_element(int idx);
      int r;
      r = $urandom_range(0, 99);
      if (idx == MAX_ELEMS - 1) return 16'h7fff;
      if (r < 3)
         elem_level = int'($urandom_range(0, 65535)) - 32768;
      else if (r < 8)
         elem_level = idx + int'($urandom_range(0, 6)) - 3;
      else if (r < 12)
         elem_level += $urandom_range(0, 300);
      else
         elem_level += $urandom_range(0, 2);
      if (elem_level > 32767) elem_level = 32767;
      if (elem_level < -32768) elem_level = -32768;
      return elem_level[ELEM_IN_W-1:0];
   endfunction

   // Lengths stay small most of the time; full prefixes and past-the-store
   // values now and then.
   function automatic int pick_length(int fill);
      int r;
      r = $urandom_range(0, 99);
      if (fill >= MAX_ELEMS && r >= 90) return $urandom_range(MAX_ELEMS, LEN_MAX);
      if (r < 15) return fill;
      if (r < 35) return $urandom_range(0, fill);
      return $urandom_range(0, (fill < 64) ? fill : 64);
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      int phase_no;
      int phase_items;
      int full_phases;
      int len;
      bit hold_phase;
      bit do_search;

      board       = new();
      phase_no    = 0;
      full_phases = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= ACT_LOAD;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_data   <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty search, loads split by a search (pointer must not
      // move), then short lengths with a miss, a hit and a wider range.
      write_length(0);
      put(ACT_SEARCH, 16'h0000);
      put(ACT_LOAD, 16'h8000);       // most negative element at index 0
      put(ACT_LOAD, -16'sd5);
      put(ACT_LOAD, 16'd2);
      put(ACT_LOAD, 16'd2);
      put(ACT_SEARCH, 16'hffff);
      put(ACT_LOAD, 16'd3);
      put(ACT_LOAD, 16'd9);
      put(ACT_LOAD, 16'd9);
      put(ACT_LOAD, 16'd9);
      settle();
      write_length(1);
      put(ACT_SEARCH, 16'h5555);
      settle();
      write_length(3);
      put(ACT_SEARCH, 16'haaaa);
      settle();
      write_length(8);
      put(ACT_SEARCH, 16'h0000);
      put(ACT_SEARCH, 16'h7fff);

      // Random phases: one length per phase, written only while idle.
      while (items < ITEM_COUNT) begin
         settle();
         if (items >= ITEM_COUNT - QUIET_ITEMS) quiet = 1'b1;
         if (loads_sent >= MAX_ELEMS && full_phases < 2) begin
            // store full: lengths at and past the store size
            len = (full_phases == 0) ? LEN_MAX : MAX_ELEMS;
            full_phases++;
         end else begin
            len = pick_length(loads_sent);
         end
         write_length(len);
         hold_phase  = (phase_no == 3);
         phase_items = hold_phase ? 10 : $urandom_range(4, 30);
         // searches pile up behind a stalled response
         if (hold_phase) long_hold = 1'b1;
         for (int k = 0; k < phase_items && items < ITEM_COUNT; k++) begin
            if (hold_phase)
               do_search = 1'b1;
            else if (loads_sent >= MAX_ELEMS)
               do_search = ($urandom_range(0, 99) >= 12);
            else
               do_search = ($urandom_range(0, 99) >= 80);
            if (do_search)
               put(ACT_SEARCH, ELEM_IN_W'($urandom));
            else
               put(ACT_LOAD, next_element(loads_sent));
         end
         phase_no++;
      end

      settle();
      repeat (20) @(posedge clock);
      if (board.errors == 0 && board.expected.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Watchdog, far beyond the slowest legal run
   initial begin
      #(100_000_000);
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/fpis_pkg.sv
rtl/core/fpis_elem_mem.sv
rtl/core/fpis_stack_mem.sv
rtl/core/fpis_probe_unit.sv
rtl/core/fixed_point_index_search_core.sv
tb/tb_top.sv
